[rtl/core/psrl_pkg.sv]
`default_nettype none
package psrl_pkg;
	localparam int BUCKETS = 256;
	localparam int WAYS = 4;
	localparam int MAX_WEIGHT = 1024;
	localparam int COUNT_BITS = 24;
	localparam int BKT_BITS = $clog2(BUCKETS);
	localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WGT_BITS = $clog2(MAX_WEIGHT) + 1;
	localparam int SLOT_BITS = BKT_BITS + $clog2(WAYS);
	localparam int NSLOTS = BUCKETS * WAYS;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	localparam logic [2:0] V_EXEMPT = 3'd0;
	localparam logic [2:0] V_PASS = 3'd1;
	localparam logic [2:0] V_BANNED = 3'd2;
	localparam logic [2:0] V_NEWBAN = 3'd3;
	localparam logic [2:0] V_BURST = 3'd4;
	localparam logic [2:0] V_NOROOM = 3'd5;

	localparam logic [2:0] R_TOTAL_LIMIT = 3'd0;
	localparam logic [2:0] R_TOTAL_WINDOW = 3'd1;
	localparam logic [2:0] R_BURST_LIMIT = 3'd2;
	localparam logic [2:0] R_BURST_WINDOW = 3'd3;
	localparam logic [2:0] R_BAN_SECONDS = 3'd4;
	localparam logic [2:0] R_URL_WEIGHTING = 3'd5;
	localparam logic [2:0] R_SKIP_INTERNAL = 3'd6;
	localparam logic [2:0] R_EXEMPT_RANGE = 3'd7;

	typedef struct packed {
		logic [COUNT_BITS-1:0] total_limit;
		logic [31:0] total_window;
		logic [COUNT_BITS-1:0] burst_limit;
		logic [31:0] burst_window;
		logic [31:0] ban_seconds;
		logic url_weighting_on;
		logic skip_internal;
		logic [63:0] exempt_range;
	} cfg_t;

	typedef struct packed {
		logic exempt;
		logic [BKT_BITS-1:0] bucket;
		logic [31:0] addr;
		logic [31:0] now;
		logic [31:0] tag;
	} job_t;

	typedef struct packed {
		logic [31:0] source;
		logic [COUNT_BITS-1:0] total_count;
		logic [COUNT_BITS-1:0] burst_count;
		logic [31:0] total_start;
		logic [31:0] burst_start;
		logic [31:0] ban_until;
		logic [31:0] url_tag;
		logic [WGT_BITS-1:0] weight;
	} slot_t;

	function automatic logic [COUNT_BITS-1:0] add_sat(input logic [COUNT_BITS-1:0] c,
			input logic [WGT_BITS-1:0] w);
		logic [COUNT_BITS:0] s;
		s = {1'b0, c} + (COUNT_BITS+1)'(w);
		return s[COUNT_BITS] ? CNT_MAX : s[COUNT_BITS-1:0];
	endfunction
endpackage
`default_nettype wire

[rtl/core/psrl_cfg.sv]
`default_nettype none
module psrl_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [5:0] paddr,
	input wire logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready,
	output psrl_pkg::cfg_t cfg
);
	import psrl_pkg::*;
	cfg_t cfg_q;
	logic [2:0] idx;
	assign idx = paddr[5:3];
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
			case (idx)
				R_TOTAL_LIMIT: cfg_q.total_limit <= pwdata[COUNT_BITS-1:0];
				R_TOTAL_WINDOW: cfg_q.total_window <= pwdata[31:0];
				R_BURST_LIMIT: cfg_q.burst_limit <= pwdata[COUNT_BITS-1:0];
				R_BURST_WINDOW: cfg_q.burst_window <= pwdata[31:0];
				R_BAN_SECONDS: cfg_q.ban_seconds <= pwdata[31:0];
				R_URL_WEIGHTING: cfg_q.url_weighting_on <= pwdata[0];
				R_SKIP_INTERNAL: cfg_q.skip_internal <= pwdata[0];
				R_EXEMPT_RANGE: cfg_q.exempt_range <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			R_TOTAL_LIMIT: prdata = 64'(cfg_q.total_limit);
			R_TOTAL_WINDOW: prdata = 64'(cfg_q.total_window);
			R_BURST_LIMIT: prdata = 64'(cfg_q.burst_limit);
			R_BURST_WINDOW: prdata = 64'(cfg_q.burst_window);
			R_BAN_SECONDS: prdata = 64'(cfg_q.ban_seconds);
			R_URL_WEIGHTING: prdata = 64'(cfg_q.url_weighting_on);
			R_SKIP_INTERNAL: prdata = 64'(cfg_q.skip_internal);
			R_EXEMPT_RANGE: prdata = cfg_q.exempt_range;
			default: prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

[rtl/core/psrl_front.sv]
`default_nettype none
module psrl_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire psrl_pkg::cfg_t cfg,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [95:0] in_data,
	input wire logic in_user,
	output logic job_valid,
	input wire logic job_ready,
	output psrl_pkg::job_t job
);
	import psrl_pkg::*;
	localparam int QD = 2;
	job_t q_q [QD];
	logic [0:0] wp_q, rp_q;
	logic [1:0] cnt_q;
	job_t nj;
	logic [31:0] a, exa, exm;
	logic push, pop;

	always_comb begin
		a = in_data[31:0];
		exa = cfg.exempt_range[63:32];
		exm = cfg.exempt_range[31:0];
		nj.addr = a;
		nj.now = in_data[63:32];
		nj.tag = in_data[95:64];
		nj.bucket = BKT_BITS'(a ^ (a >> 2) ^ (a >> 6));
		nj.exempt = (cfg.skip_internal && in_user) || (exa != 0 && exa == (a & exm));
	end

	assign in_ready = cnt_q != 2'(QD);
	assign push = in_valid && in_ready;
	assign job_valid = cnt_q != 0;
	assign pop = job_valid && job_ready;
	assign job = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) q_q[wp_q] <= nj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

[rtl/core/psrl_back.sv]
`default_nettype none
module psrl_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire psrl_pkg::cfg_t cfg,
	input wire logic job_valid,
	output logic job_ready,
	input wire psrl_pkg::job_t job,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] out_verdict,
	output logic [10:0] out_weight
);
	import psrl_pkg::*;

	typedef enum logic [5:0] {
		S_CLR = 6'b000001,
		S_IDLE = 6'b000010,
		S_READ = 6'b000100,
		S_SCAN = 6'b001000,
		S_UPD = 6'b010000,
		S_OUT = 6'b100000
	} state_t;

	state_t st_q;
	job_t j_q;
	slot_t mem [NSLOTS];
	logic vmem [NSLOTS];
	slot_t rd_q;
	logic rv_q;
	logic [SLOT_BITS-1:0] clr_q;
	logic [WAY_BITS:0] way_q;
	logic [WAY_BITS-1:0] free_q;
	logic free_f_q;
	logic [2:0] verd_q;
	logic [10:0] wgt_q;
	logic [32:0] life;
	logic [SLOT_BITS-1:0] ridx, cidx, fidx;
	logic [31:0] age_t, age_b;
	logic stale;
	slot_t u;
	logic [2:0] uv;
	logic [32:0] dl;
	logic [WGT_BITS:0] dbl;
	logic wr;

	assign life = {(cfg.total_window > cfg.ban_seconds ? cfg.total_window :
		cfg.ban_seconds), 1'b0};
	assign ridx = SLOT_BITS'({j_q.bucket, way_q[WAY_BITS-1:0]} >> (WAY_BITS -
		$clog2(WAYS)));
	assign cidx = SLOT_BITS'((SLOT_BITS+1)'(j_q.bucket) * (SLOT_BITS+1)'(WAYS)
		+ (SLOT_BITS+1)'(way_q));
	assign fidx = SLOT_BITS'((SLOT_BITS+1)'(j_q.bucket) * (SLOT_BITS+1)'(WAYS)
		+ (SLOT_BITS+1)'(free_q));
	assign job_ready = st_q == S_IDLE;
	assign out_valid = st_q == S_OUT;
	assign out_verdict = verd_q;
	assign out_weight = wgt_q;
	assign age_t = j_q.now - rd_q.total_start;
	assign age_b = j_q.now - rd_q.burst_start;
	assign stale = {1'b0, age_t} > life;

	always_comb begin
		u = rd_q;
		uv = V_PASS;
		dbl = {rd_q.weight, 1'b0};
		dl = {1'b0, j_q.now} + {1'b0, cfg.ban_seconds};
		if (cfg.url_weighting_on) begin
			if (rd_q.url_tag == j_q.tag)
				u.weight = dbl > (WGT_BITS+1)'(MAX_WEIGHT) ? WGT_BITS'(MAX_WEIGHT) :
					dbl[WGT_BITS-1:0];
			else begin
				u.weight = WGT_BITS'(1);
				u.url_tag = j_q.tag;
			end
		end
		if (cfg.burst_limit != 0 && age_b > cfg.burst_window) begin
			u.burst_count = '0;
			u.burst_start = j_q.now;
		end
		if (cfg.total_limit != 0 && age_t > cfg.total_window) begin
			u.total_count = '0;
			u.total_start = j_q.now;
			u.weight = WGT_BITS'(1);
		end
		u.total_count = add_sat(u.total_count, u.weight);
		u.burst_count = add_sat(u.burst_count, u.weight);
		if (cfg.total_limit != 0 && u.total_count > cfg.total_limit) begin
			u.ban_until = dl[32] ? 32'hFFFF_FFFF : dl[31:0];
			uv = V_NEWBAN;
		end else if (cfg.burst_limit != 0 && u.burst_count > cfg.burst_limit) begin
			uv = V_BURST;
		end
	end

	assign wr = st_q == S_UPD && rd_q.ban_until <= j_q.now;

	always_ff @(posedge clk) begin
		if (st_q == S_READ) begin
			rd_q <= mem[ridx];
			rv_q <= vmem[ridx];
		end
		if (wr) mem[cidx] <= u;
		if (st_q == S_SCAN && way_q[WAY_BITS] == 1'b1 && free_f_q)
			mem[fidx] <= '{source: j_q.addr, total_count: COUNT_BITS'(1),
				burst_count: COUNT_BITS'(1), total_start: j_q.now, burst_start: j_q.now,
				ban_until: '0, url_tag: j_q.tag, weight: WGT_BITS'(1)};
		if (st_q == S_CLR)
			vmem[clr_q] <= 1'b0;
		else if (st_q == S_SCAN && way_q[WAY_BITS] == 1'b1 && free_f_q)
			vmem[fidx] <= 1'b1;
		else if (st_q == S_SCAN && way_q[WAY_BITS] == 1'b0 && rv_q &&
				rd_q.source != j_q.addr && stale)
			vmem[cidx] <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			clr_q <= '0;
			way_q <= '0;
			free_q <= '0;
			free_f_q <= 1'b0;
			verd_q <= V_EXEMPT;
			wgt_q <= '0;
			j_q <= '0;
		end else begin
			case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_BITS'(NSLOTS - 1)) st_q <= S_IDLE;
				end
				S_IDLE: if (job_valid) begin
					j_q <= job;
					way_q <= '0;
					free_f_q <= 1'b0;
					if (job.exempt) begin
						verd_q <= V_EXEMPT;
						wgt_q <= '0;
						st_q <= S_OUT;
					end else st_q <= S_READ;
				end
				S_READ: st_q <= S_SCAN;
				S_SCAN: begin
					if (way_q[WAY_BITS] == 1'b1 && (WAYS > 1 || way_q != 0)) begin
						if (free_f_q) begin
							verd_q <= V_PASS;
							wgt_q <= 11'd1;
						end else begin
							verd_q <= V_NOROOM;
							wgt_q <= '0;
						end
						st_q <= S_OUT;
					end else if (rv_q && rd_q.source == j_q.addr) begin
						st_q <= S_UPD;
					end else begin
						if (!free_f_q && (!rv_q || stale)) begin
							free_f_q <= 1'b1;
							free_q <= way_q[WAY_BITS-1:0];
						end
						way_q <= way_q + 1'b1;
						st_q <= (way_q == (WAY_BITS+1)'(WAYS - 1)) ? S_SCAN : S_READ;
						if (way_q == (WAY_BITS+1)'(WAYS - 1))
							way_q <= {1'b1, {WAY_BITS{1'b0}}};
					end
				end
				S_UPD: begin
					if (rd_q.ban_until > j_q.now) begin
						verd_q <= V_BANNED;
						wgt_q <= '0;
					end else begin
						verd_q <= uv;
						wgt_q <= 11'(u.weight);
					end
					st_q <= S_OUT;
				end
				S_OUT: if (out_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/core/per_source_rate_limiter_top.sv]
// per-source rate limiter
// input stream: s_tdata = {url_tag, now_seconds, source_addr}, s_tuser = is_internal
// output stream: m_tdata = {request_weight, verdict}, one word per input word
// configuration through the apb port, registers 8 bytes apart
// a two-entry queue holds hashed, classified requests for the back end
// the back end reads the ways of the bucket in turn until one matches (a read state
// and a compare state per way), then updates the matching slot unless the source is
// banned, or claims a free or stale way, if any, for a new source; exempt requests skip the scan
// the front keeps accepting while the queue has room
// a result waits in the output register until m_tready; the back end takes no new request meanwhile
// reset clears configuration and queue, then the back end clears all NSLOTS slot
// valid bits before it takes the first request
`default_nettype none
module per_source_rate_limiter_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [95:0] s_tdata, // source_addr, now_seconds, url_tag
	input wire logic s_tuser, // is_internal
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [15:0] m_tdata, // verdict, request_weight, zero pad
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [5:0] paddr,
	input wire logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);
	import psrl_pkg::*;
	cfg_t cfg;
	job_t job;
	logic job_valid, job_ready;
	logic [2:0] verd;
	logic [10:0] wgt;

	psrl_cfg u_cfg (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg);
	psrl_front u_front (.clk, .arst_n, .cfg, .in_valid(s_tvalid), .in_ready(s_tready),
		.in_data(s_tdata), .in_user(s_tuser), .job_valid, .job_ready, .job);
	psrl_back u_back (.clk, .arst_n, .cfg, .job_valid, .job_ready, .job,
		.out_valid(m_tvalid), .out_ready(m_tready), .out_verdict(verd), .out_weight(wgt));
	assign m_tdata = {2'b00, wgt, verd};
endmodule
`default_nettype wire

[rtl/core/psrl_checker.sv]
`default_nettype none
module psrl_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic pready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("hold");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= 3'd5) else $error("code");
	a_wzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == 3'd0 || m_tdata[2:0] == 3'd2 ||
		m_tdata[2:0] == 3'd5) |-> m_tdata[13:3] == 11'd0) else $error("weight");
	a_rdy: assert property (@(posedge clk) pready) else $error("pready");
endmodule
bind per_source_rate_limiter_top psrl_checker u_chk (.clk, .arst_n, .m_tvalid,
	.m_tready, .m_tdata, .pready);
`default_nettype wire
